// ----- hw/rtl/bipartite_graph_check_unit_assert.svh -----
// Assertion macros for the bipartite graph check unit.
// Each macro expects clk and arst_n in scope.
`ifndef BIPARTITE_GRAPH_CHECK_UNIT_ASSERT_SVH
`define BIPARTITE_GRAPH_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BGC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BGC_ASSERT_NOW(lbl, ante, cons, msg)
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/bgc_pkg.sv -----
package bgc_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int VCOUNT_W         = 9;
	localparam int VERTEX_W         = 8;
	localparam int PADDR_W          = 3;
	localparam int PDATA_W          = 32;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

	// register index, taken from paddr[2]
	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic {
		OP_ADD_EDGE = 1'b0,
		OP_EVALUATE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND_A,
		ST_FIND_B
	} state_t;

	typedef struct packed {
		op_t                 operation;
		logic [VERTEX_W-1:0] edge_from;
		logic [VERTEX_W-1:0] edge_to;
	} edge_item_t;

	typedef struct packed {
		logic feasible;
		logic bad_edge;
	} result_item_t;

endpackage

// ----- hw/rtl/bipartite_graph_check_unit.sv -----
// An edge walks the parent table from each end up to its root, one read per hop, then joins the roots.
// Throughput: one item at a time; the union-find walk through the parent table sets it.
// An evaluate returns its result in the cycle after the transfer, then clears the whole table,
// during which no item is taken (configuration writes still are).
// Reset: asynchronous, active low; starts the same clearing pass, vertex_count returns to 256.
`include "bipartite_graph_check_unit_assert.svh"

module bipartite_graph_check_unit #(
	parameter int MAX_VERTICES = bgc_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// edge channel
	input  logic                          edge_valid,
	output logic                          edge_ready,
	input  bgc_pkg::edge_item_t           edge_item,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output bgc_pkg::result_item_t         result_item,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgc_pkg::PADDR_W-1:0]   paddr,
	input  logic [bgc_pkg::PDATA_W-1:0]   pwdata,
	output logic [bgc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bgc_pkg::*;

	// vertex index width, and a compare width that holds both vertex_count and MAX_VERTICES
	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = ((VW > VCOUNT_W) ? VW : VCOUNT_W) + 1;
	localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

	// one table entry: parent and the colour relative to that parent
	typedef struct packed {
		logic [VW-1:0] root;
		logic          par;
	} entry_t;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [VCOUNT_W-1:0] vertex_count_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_wr) begin
			vertex_count_q <= pwdata[VCOUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_VERTEX_COUNT) begin
			prdata = PDATA_W'(vertex_count_q);
		end
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t        state_q, state_d;
	logic [VW-1:0] clr_cnt_q;      // clearing pass position
	logic          conflict_q;     // odd cycle found since the last clear
	logic          bad_seen_q;     // out-of-range edge since the last clear
	logic          result_valid_q;
	result_item_t  result_q;

	// walk registers (payload, no reset)
	logic [VW-1:0] cur_q;          // vertex currently being walked
	logic          col_q;          // colour of the start vertex relative to cur_q
	logic [VW-1:0] b_q;            // second end, held while the first is walked
	logic [VW-1:0] ra_q;           // root of the first end
	logic          ca_q;           // colour of the first end relative to ra_q

	// parent table and its registered read port
	entry_t        mem [MAX_VERTICES];
	entry_t        rd_q;
	logic          rd_en;
	logic [VW-1:0] rd_addr;
	logic          mem_we;
	logic [VW-1:0] wr_addr;
	entry_t        wr_data;

	logic          xfer_in;
	logic          is_eval;
	logic [CW-1:0] a_w, b_w;
	logic          out_of_range;
	logic [VW-1:0] a_idx, b_idx;
	logic          at_root;

	// take a new item only when idle; hold an evaluate while the result slot is full
	// and not draining, edges never touch the slot and pass regardless
	assign edge_ready = (state_q == ST_IDLE) &&
	                    (!(edge_valid && is_eval) || !result_valid_q || result_ready);
	assign xfer_in    = edge_valid && edge_ready;
	assign is_eval    = (edge_item.operation == OP_EVALUATE);

	// range check against both the configured count and the table size
	assign a_w = CW'(edge_item.edge_from);
	assign b_w = CW'(edge_item.edge_to);
	assign out_of_range = (a_w >= CW'(vertex_count_q)) || (b_w >= CW'(vertex_count_q)) ||
	                      (a_w >= CW'(MAX_VERTICES)) || (b_w >= CW'(MAX_VERTICES));
	assign a_idx = VW'(a_w);
	assign b_idx = VW'(b_w);

	// the entry just read is a root when it points at itself
	assign at_root = (rd_q.root == cur_q);

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	// ------------------------------------------------------------------
	// Next state, table read and write requests
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = cur_q;
		mem_we  = 1'b0;
		wr_addr = clr_cnt_q;
		wr_data = '{root: clr_cnt_q, par: 1'b0};
		case (state_q)
			ST_CLEAR: begin
				// write every vertex back as its own root
				mem_we = 1'b1;
				if (clr_cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (xfer_in && is_eval) begin
					state_d = ST_CLEAR;
				end else if (xfer_in && !out_of_range) begin
					rd_en   = 1'b1;
					rd_addr = a_idx;
					state_d = ST_FIND_A;
				end
			end
			ST_FIND_A: begin
				// hop to the parent, or start on the second end once at the root
				rd_en = 1'b1;
				if (at_root) begin
					rd_addr = b_q;
					state_d = ST_FIND_B;
				end else begin
					rd_addr = rd_q.root;
				end
			end
			ST_FIND_B: begin
				if (at_root) begin
					state_d = ST_IDLE;
					// different trees: hang the first root under the second
					if (ra_q != cur_q) begin
						mem_we  = 1'b1;
						wr_addr = ra_q;
						wr_data = '{root: cur_q, par: ca_q ^ col_q ^ 1'b1};
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_q.root;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Parent table: one write and one registered read per cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			conflict_q     <= 1'b0;
			bad_seen_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// drop the result once the far side takes it, unless a new one replaces it
			if (result_valid_q && result_ready && !(xfer_in && is_eval)) begin
				result_valid_q <= 1'b0;
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (xfer_in && is_eval) begin
				result_valid_q <= 1'b1;
				conflict_q     <= 1'b0;
				bad_seen_q     <= 1'b0;
				clr_cnt_q      <= '0;
			end else if (xfer_in && out_of_range) begin
				bad_seen_q <= 1'b1;
			end
			// both ends in one tree with the same colour: odd cycle
			if ((state_q == ST_FIND_B) && at_root && (ra_q == cur_q) && (ca_q == col_q)) begin
				conflict_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Walk and result payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (xfer_in && is_eval) begin
			result_q <= '{feasible: !conflict_q, bad_edge: bad_seen_q};
		end
		case (state_q)
			ST_IDLE: begin
				cur_q <= a_idx;
				col_q <= 1'b0;
				b_q   <= b_idx;
			end
			ST_FIND_A: begin
				if (at_root) begin
					ra_q  <= cur_q;
					ca_q  <= col_q;
					cur_q <= b_q;
					col_q <= 1'b0;
				end else begin
					cur_q <= rd_q.root;
					col_q <= col_q ^ rd_q.par;
				end
			end
			ST_FIND_B: begin
				if (!at_root) begin
					cur_q <= rd_q.root;
					col_q <= col_q ^ rd_q.par;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BGC_ASSERT_NEXT(a_eval_result, xfer_in && is_eval, result_valid_q && (state_q == ST_CLEAR), "evaluate transfer did not raise a result and start clearing")
	`BGC_ASSERT_NEXT(a_eval_flags, xfer_in && is_eval, !conflict_q && !bad_seen_q, "flags not cleared after evaluate")
	`BGC_ASSERT_NOW(a_write_state, mem_we, (state_q == ST_CLEAR) || (state_q == ST_FIND_B), "table written outside clearing or union")
	`BGC_ASSERT_NOW(a_no_rw_clash, mem_we, !rd_en, "table read and written in the same cycle")

endmodule
